### hdl/dgam_pkg.sv
// Shared constants for the diagonal gate amplitude multiplier.
package dgam_pkg;

  // Coefficient format: signed Q2.30 real and imaginary halves.
  localparam int unsigned COEF_BITS = 32;
  localparam int unsigned COEF_FRAC = 30;

  // Unity coefficient (1.0 + 0.0i), also the reset value.
  localparam logic [2*COEF_BITS-1:0] COEF_ONE = 64'h4000_0000_0000_0000;

  // Output index width, fixed by the result format.
  localparam int unsigned OUT_IDX_BITS = 32;

  // Configuration register map.
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF0    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF1    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF2    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF3    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_POS_LOW  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_POS_HIGH = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_GATE_QB  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE   = 3'd7;

  // Register field widths.
  localparam int unsigned POS_BITS   = 5;
  localparam int unsigned GQ_BITS    = 2;
  localparam int unsigned N_ENTRIES  = 4;
  localparam int unsigned ENTRY_BITS = 2;

endpackage

### hdl/diagonal_gate_amplitude_multiply_core.sv
// Diagonal gate amplitude multiplier: three-stage streaming complex multiply.
//
// Usage: one statevector amplitude (index, real, imaginary) enters per beat on
// the input channel (in_valid_i / in_stall_o); one result beat leaves per
// accepted beat on the output channel (out_valid_o / out_stall_i), in order.
// The index bits at the configured qubit positions pick one of four diagonal
// entries; an enabled entry multiplies the amplitude by its Q2.30 complex
// coefficient, a disabled one passes the amplitude through unchanged.
// Each beat passes the operand register, the product register (four 32-bit
// multipliers), then round/saturate into the output register.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the output holds its beat and each stage keeps
// taking new beats until it is full; in_stall_o rises only when all three
// stages hold data. Reset empties the pipeline and loads the configuration
// defaults: all coefficients 1.0, positions 0 and 1, one-qubit mode, all
// entries enabled. Configuration writes (cfg_valid_i, always ready) are meant
// to be done while the pipeline is empty.
module diagonal_gate_amplitude_multiply_core #(
  parameter int unsigned INDEX_BITS      = 32,
  parameter int unsigned AMP_BITS        = 32,
  parameter int unsigned MAX_GATE_QUBITS = 2
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dgam_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [2*dgam_pkg::COEF_BITS-1:0]       cfg_data_i,
  // Input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [INDEX_BITS-1:0]                  amp_index_i,
  input  logic signed [AMP_BITS-1:0]             amp_re_i,
  input  logic signed [AMP_BITS-1:0]             amp_im_i,
  // Output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [dgam_pkg::OUT_IDX_BITS-1:0]      out_index_o,
  output logic signed [AMP_BITS-1:0]             out_re_o,
  output logic signed [AMP_BITS-1:0]             out_im_o,
  output logic                                   saturated_o
);

  localparam int unsigned CB    = dgam_pkg::COEF_BITS;
  localparam int unsigned OIB   = dgam_pkg::OUT_IDX_BITS;
  localparam int unsigned PW    = CB + AMP_BITS;       // product width
  localparam int unsigned SW    = PW + 1;              // sum of two products
  localparam int unsigned RW    = SW - dgam_pkg::COEF_FRAC;  // after shift
  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (dgam_pkg::COEF_FRAC - 1);
  localparam logic signed [AMP_BITS-1:0] AMP_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
  localparam logic signed [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [2*CB-1:0]                    coef_q [dgam_pkg::N_ENTRIES];
  logic [dgam_pkg::POS_BITS-1:0]      pos_low_q;
  logic [dgam_pkg::POS_BITS-1:0]      pos_high_q;
  logic [dgam_pkg::GQ_BITS-1:0]       gate_qb_q;
  logic [dgam_pkg::N_ENTRIES-1:0]     enable_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < dgam_pkg::N_ENTRIES; k++) begin
        coef_q[k] <= dgam_pkg::COEF_ONE;
      end
      pos_low_q  <= '0;
      pos_high_q <= dgam_pkg::POS_BITS'(1);
      gate_qb_q  <= dgam_pkg::GQ_BITS'(1);
      enable_q   <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dgam_pkg::REG_COEF0:    coef_q[0]  <= cfg_data_i;
        dgam_pkg::REG_COEF1:    coef_q[1]  <= cfg_data_i;
        dgam_pkg::REG_COEF2:    coef_q[2]  <= cfg_data_i;
        dgam_pkg::REG_COEF3:    coef_q[3]  <= cfg_data_i;
        dgam_pkg::REG_POS_LOW:  pos_low_q  <= cfg_data_i[dgam_pkg::POS_BITS-1:0];
        dgam_pkg::REG_POS_HIGH: pos_high_q <= cfg_data_i[dgam_pkg::POS_BITS-1:0];
        dgam_pkg::REG_GATE_QB:  gate_qb_q  <= cfg_data_i[dgam_pkg::GQ_BITS-1:0];
        dgam_pkg::REG_ENABLE:   enable_q   <= cfg_data_i[dgam_pkg::N_ENTRIES-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage moves when it is empty or the next moves
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: entry lookup and operand register
  // ---------------------------------------------------------------------------
  logic [OIB-1:0]                  idx_lo;
  logic                            bit_low, bit_high;
  logic [dgam_pkg::ENTRY_BITS-1:0] entry;
  logic [2*CB-1:0]                 coef_sel;
  logic                            two_qubit;

  // Low 32 index bits; positions beyond INDEX_BITS read as zero padding.
  if (INDEX_BITS >= OIB) begin : g_idx_trunc
    assign idx_lo = amp_index_i[OIB-1:0];
  end else begin : g_idx_pad
    assign idx_lo = {{(OIB-INDEX_BITS){1'b0}}, amp_index_i};
  end

  assign two_qubit = (MAX_GATE_QUBITS >= 2) && gate_qb_q[1];

  always_comb begin
    bit_low  = idx_lo[pos_low_q];
    bit_high = two_qubit ? idx_lo[pos_high_q] : 1'b0;
    entry    = {bit_high, bit_low};
    // Disabled entry multiplies by exactly 1.0, which reproduces the input.
    coef_sel = enable_q[entry] ? coef_q[entry] : dgam_pkg::COEF_ONE;
  end

  logic [OIB-1:0]               idx1_q;
  logic signed [AMP_BITS-1:0]   ar1_q, ai1_q;
  logic signed [CB-1:0]         cr1_q, ci1_q;

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      idx1_q <= idx_lo;
      ar1_q  <= amp_re_i;
      ai1_q  <= amp_im_i;
      cr1_q  <= coef_sel[2*CB-1:CB];
      ci1_q  <= coef_sel[CB-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: four partial products
  // ---------------------------------------------------------------------------
  logic [OIB-1:0]        idx2_q;
  logic signed [PW-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      idx2_q <= idx1_q;
      p_rr_q <= PW'(cr1_q) * PW'(ar1_q);
      p_ii_q <= PW'(ci1_q) * PW'(ai1_q);
      p_ri_q <= PW'(cr1_q) * PW'(ai1_q);
      p_ir_q <= PW'(ci1_q) * PW'(ar1_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum, round half up, saturate into the output register
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0]        sum_re, sum_im;
  logic signed [RW-1:0]        rnd_re, rnd_im;
  logic                        ovf_re, ovf_im;
  logic signed [AMP_BITS-1:0]  re_d, im_d;

  always_comb begin
    sum_re = SW'(p_rr_q) - SW'(p_ii_q) + RND_HALF;
    sum_im = SW'(p_ri_q) + SW'(p_ir_q) + RND_HALF;
    rnd_re = sum_re[SW-1:dgam_pkg::COEF_FRAC];
    rnd_im = sum_im[SW-1:dgam_pkg::COEF_FRAC];
    // In range when all bits above the target sign bit match it.
    ovf_re = !((&rnd_re[RW-1:AMP_BITS-1]) || !(|rnd_re[RW-1:AMP_BITS-1]));
    ovf_im = !((&rnd_im[RW-1:AMP_BITS-1]) || !(|rnd_im[RW-1:AMP_BITS-1]));
    re_d   = ovf_re ? (rnd_re[RW-1] ? AMP_MIN : AMP_MAX) : rnd_re[AMP_BITS-1:0];
    im_d   = ovf_im ? (rnd_im[RW-1] ? AMP_MIN : AMP_MAX) : rnd_im[AMP_BITS-1:0];
  end

  logic [OIB-1:0]              idx3_q;
  logic signed [AMP_BITS-1:0]  re3_q, im3_q;
  logic                        sat3_q;

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      idx3_q <= idx2_q;
      re3_q  <= re_d;
      im3_q  <= im_d;
      sat3_q <= ovf_re || ovf_im;
    end
  end

  assign out_valid_o = v3_q;
  assign out_index_o = idx3_q;
  assign out_re_o    = re3_q;
  assign out_im_o    = im3_q;
  assign saturated_o = sat3_q;

endmodule

### tb/diagonal_gate_amplitude_multiply_core_test.sv
// Self-checking testbench for the diagonal gate amplitude multiplier core.
module diagonal_gate_amplitude_multiply_core_test;

  localparam int unsigned IDX_W = 32;
  localparam int unsigned AMP_W = 32;
  localparam int unsigned CW    = dgam_pkg::COEF_BITS;
  localparam logic signed [AMP_W-1:0] AMP_MAX = 32'sh7fff_ffff;
  localparam logic signed [AMP_W-1:0] AMP_MIN = 32'sh8000_0000;
  localparam logic [CW-1:0] Q_ONE  = 32'h4000_0000;
  localparam logic [CW-1:0] Q_HALF = 32'h2000_0000;
  localparam logic [CW-1:0] Q_NEG1 = 32'hc000_0000;
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 120;

  // One result beat as the core should produce it
  typedef struct packed {
    logic [dgam_pkg::OUT_IDX_BITS-1:0] index;
    logic signed [AMP_W-1:0]           re;
    logic signed [AMP_W-1:0]           im;
    logic                              sat;
  } amp_result_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic [dgam_pkg::CFG_IDX_BITS-1:0]    cfg_index_i;
  logic [2*CW-1:0]                      cfg_data_i;
  logic                                 in_valid_i;
  logic                                 in_stall_o;
  logic [IDX_W-1:0]                     amp_index_i;
  logic signed [AMP_W-1:0]              amp_re_i;
  logic signed [AMP_W-1:0]              amp_im_i;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic [dgam_pkg::OUT_IDX_BITS-1:0]    out_index_o;
  logic signed [AMP_W-1:0]              out_re_o;
  logic signed [AMP_W-1:0]              out_im_o;
  logic                                 saturated_o;

  // Gate setting as the core should hold it
  logic [2*CW-1:0]                      coef_q [dgam_pkg::N_ENTRIES];
  logic [dgam_pkg::POS_BITS-1:0]        pos_lo;
  logic [dgam_pkg::POS_BITS-1:0]        pos_hi;
  logic [dgam_pkg::GQ_BITS-1:0]         gate_qb;
  logic [dgam_pkg::N_ENTRIES-1:0]       entry_en;

  amp_result_t                expected_amps [$];
  int unsigned                fail_count = 0;
  int unsigned                sent_count = 0;
  int unsigned                checked_count = 0;
  int unsigned                setting_count = 0;
  bit                         steady = 1'b0;

  diagonal_gate_amplitude_multiply_core #(
    .INDEX_BITS      (IDX_W),
    .AMP_BITS        (AMP_W),
    .MAX_GATE_QUBITS (2)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .amp_index_i (amp_index_i),
    .amp_re_i    (amp_re_i),
    .amp_im_i    (amp_im_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_index_o (out_index_o),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .saturated_o (saturated_o)
  );

  always #2 clk_i = ~clk_i;

  // Round a Q6.60 sum to Q2.30 (ties up), then clip to the amplitude range
  function automatic logic signed [AMP_W-1:0] round_clip(input logic signed [65:0] acc,
                                                          inout logic sat);
    logic signed [65:0] r;
    r = (acc + 66'sd536870912) >>> dgam_pkg::COEF_FRAC;
    if (r > AMP_MAX) begin
      sat = 1'b1;
      return AMP_MAX;
    end
    if (r < AMP_MIN) begin
      sat = 1'b1;
      return AMP_MIN;
    end
    return r[AMP_W-1:0];
  endfunction

  // Apply the configured diagonal gate to one amplitude
  function automatic amp_result_t diag_multiply(input logic [IDX_W-1:0] idx,
                                                input logic signed [AMP_W-1:0] re,
                                                input logic signed [AMP_W-1:0] im);
    logic [dgam_pkg::ENTRY_BITS-1:0] entry;
    logic signed [CW-1:0] cr;
    logic signed [CW-1:0] ci;
    logic signed [65:0] p_rr;
    logic signed [65:0] p_ii;
    logic signed [65:0] p_ri;
    logic signed [65:0] p_ir;
    logic sat;
    amp_result_t res;
    entry = {1'b0, idx[pos_lo]};
    // gate_qubits 0 acts as one qubit, 3 as two
    if (gate_qb >= 2) entry[1] = idx[pos_hi];
    sat = 1'b0;
    res.index = idx;
    if (entry_en[entry]) begin
      cr = coef_q[entry][2*CW-1:CW];
      ci = coef_q[entry][CW-1:0];
      p_rr = cr * re;
      p_ii = ci * im;
      p_ri = cr * im;
      p_ir = ci * re;
      res.re = round_clip(p_rr - p_ii, sat);
      res.im = round_clip(p_ri + p_ir, sat);
    end else begin
      res.re = re;
      res.im = im;
    end
    res.sat = sat;
    return res;
  endfunction

  function automatic logic signed [AMP_W-1:0] rand_amp();
    case ($urandom_range(7))
      0: return AMP_MAX;
      1: return AMP_MIN;
      2: return 32'(int'($urandom_range(4096)) - 2048);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2*CW-1:0] rand_coef();
    case ($urandom_range(7))
      0: return dgam_pkg::COEF_ONE;
      1: return {AMP_MIN, AMP_MIN};
      2: return {AMP_MAX, AMP_MAX};
      3: return {32'h0, Q_ONE};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic void reset_gate_model();
    for (int k = 0; k < dgam_pkg::N_ENTRIES; k++) coef_q[k] = dgam_pkg::COEF_ONE;
    pos_lo = 5'd0;
    pos_hi = 5'd1;
    gate_qb = 2'd1;
    entry_en = '1;
  endfunction

  // Send one amplitude beat; called and returns at a falling edge
  task automatic send_amp(input logic [IDX_W-1:0] idx, input logic signed [AMP_W-1:0] re,
                          input logic signed [AMP_W-1:0] im);
    if (!steady && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    amp_index_i <= idx;
    amp_re_i    <= re;
    amp_im_i    <= im;
    do @(posedge clk_i); while (in_stall_o);
    expected_amps.push_back(diag_multiply(idx, re, im));
    sent_count++;
    @(negedge clk_i);
  endtask

  // Drain the pipeline before touching the configuration
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (expected_amps.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write; the pipeline must be empty
  task automatic write_reg(input logic [dgam_pkg::CFG_IDX_BITS-1:0] ridx,
                           input logic [2*CW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ridx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (ridx)
      dgam_pkg::REG_COEF0, dgam_pkg::REG_COEF1,
      dgam_pkg::REG_COEF2, dgam_pkg::REG_COEF3: coef_q[ridx[1:0]] = data;
      dgam_pkg::REG_POS_LOW:  pos_lo   = data[dgam_pkg::POS_BITS-1:0];
      dgam_pkg::REG_POS_HIGH: pos_hi   = data[dgam_pkg::POS_BITS-1:0];
      dgam_pkg::REG_GATE_QB:  gate_qb  = data[dgam_pkg::GQ_BITS-1:0];
      dgam_pkg::REG_ENABLE:   entry_en = data[dgam_pkg::N_ENTRIES-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Program a whole gate; unused upper bits of narrow registers carry noise
  task automatic load_gate(input logic [2*CW-1:0] c0, input logic [2*CW-1:0] c1,
                           input logic [2*CW-1:0] c2, input logic [2*CW-1:0] c3,
                           input logic [dgam_pkg::POS_BITS-1:0] plo,
                           input logic [dgam_pkg::POS_BITS-1:0] phi,
                           input logic [dgam_pkg::GQ_BITS-1:0] gq,
                           input logic [dgam_pkg::N_ENTRIES-1:0] en);
    logic [2*CW-1:0] pad;
    quiesce();
    write_reg(dgam_pkg::REG_COEF0, c0);
    write_reg(dgam_pkg::REG_COEF1, c1);
    write_reg(dgam_pkg::REG_COEF2, c2);
    write_reg(dgam_pkg::REG_COEF3, c3);
    pad = {$urandom(), $urandom()};
    pad[dgam_pkg::POS_BITS-1:0] = plo;
    write_reg(dgam_pkg::REG_POS_LOW, pad);
    pad = {$urandom(), $urandom()};
    pad[dgam_pkg::POS_BITS-1:0] = phi;
    write_reg(dgam_pkg::REG_POS_HIGH, pad);
    pad = {$urandom(), $urandom()};
    pad[dgam_pkg::GQ_BITS-1:0] = gq;
    write_reg(dgam_pkg::REG_GATE_QB, pad);
    pad = {$urandom(), $urandom()};
    pad[dgam_pkg::N_ENTRIES-1:0] = en;
    write_reg(dgam_pkg::REG_ENABLE, pad);
    setting_count++;
  endtask

  // Reset values: unity coefficients, one qubit at bit 0
  task automatic test_reset_defaults();
    send_amp('0, AMP_MAX, AMP_MIN);
    send_amp('1, AMP_MIN, AMP_MAX);
    send_amp(32'h1, 32'sd0, -32'sd1);
    send_amp(32'h8000_0000, 32'sd1, 32'sh4000_0000);
  endtask

  // Extreme coefficients, saturation both ways, rounding ties
  task automatic test_coef_extremes();
    load_gate({AMP_MIN, AMP_MIN}, {AMP_MAX, AMP_MAX}, {Q_HALF, 32'h0}, {32'h0, Q_NEG1},
              5'd0, 5'd1, 2'd2, 4'hf);
    send_amp(32'h0, AMP_MIN, AMP_MIN);
    send_amp(32'h0, AMP_MAX, AMP_MAX);
    send_amp(32'h1, AMP_MAX, AMP_MIN);
    send_amp(32'h2, 32'sd1, -32'sd1);
    send_amp(32'h3, AMP_MIN, 32'sd3);
  endtask

  // Entry selection, disabled entries, gate_qubits 0 and 3, equal positions
  task automatic test_entry_select();
    load_gate({32'h0, Q_ONE}, dgam_pkg::COEF_ONE, {AMP_MAX, 32'h0}, {AMP_MIN, AMP_MIN},
              5'd31, 5'd0, 2'd2, 4'b0101);
    send_amp(32'h0000_0000, 32'sh1234_5678, -32'sh0765_4321);
    send_amp(32'h8000_0000, AMP_MIN, AMP_MAX);
    send_amp(32'h0000_0001, AMP_MAX, AMP_MIN);
    send_amp(32'h8000_0001, AMP_MIN, AMP_MIN);
    quiesce();
    write_reg(dgam_pkg::REG_GATE_QB, 64'(2'd3));
    send_amp(32'h7fff_ffff, AMP_MAX, 32'sd1);
    quiesce();
    write_reg(dgam_pkg::REG_GATE_QB, 64'(2'd0));
    send_amp(32'h0000_0001, AMP_MAX, AMP_MAX);
    send_amp(32'h8000_0001, AMP_MIN, 32'sd5);
    quiesce();
    write_reg(dgam_pkg::REG_GATE_QB, 64'(2'd2));
    write_reg(dgam_pkg::REG_POS_HIGH, 64'(5'd31));
    send_amp(32'h8000_0000, AMP_MIN, AMP_MIN);
    send_amp(32'h7fff_ffff, 32'sd7, -32'sd7);
  endtask

  // Random gate settings, the first few pinned to extremes, random amplitudes
  task automatic test_random_phases();
    logic [dgam_pkg::POS_BITS-1:0]  plo;
    logic [dgam_pkg::POS_BITS-1:0]  phi;
    logic [dgam_pkg::GQ_BITS-1:0]   gq;
    logic [dgam_pkg::N_ENTRIES-1:0] en;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      plo = 5'($urandom_range(31));
      phi = 5'($urandom_range(31));
      gq  = 2'($urandom_range(3));
      en  = 4'($urandom_range(15));
      case (ph)
        0: begin plo = 5'd0;  phi = 5'd31; gq = 2'd2; en = 4'hf; end
        1: begin plo = 5'd31; phi = 5'd31; gq = 2'd3; en = 4'h0; end
        2: begin plo = 5'd31; phi = 5'd0;  gq = 2'd1; en = 4'hf; end
        3: begin gq = 2'd0; en = 4'hf; end
        default: ;
      endcase
      if (ph == 0)
        load_gate({AMP_MIN, AMP_MIN}, {AMP_MAX, AMP_MAX}, {AMP_MIN, AMP_MAX},
                  {AMP_MAX, AMP_MIN}, plo, phi, gq, en);
      else
        load_gate(rand_coef(), rand_coef(), rand_coef(), rand_coef(), plo, phi, gq, en);
      // one phase runs with no idling on either side
      steady = (ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) send_amp(rand_index(), rand_amp(), rand_amp());
    end
    steady = 1'b0;
  endtask

  // Random receiver stalls
  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 17);
  end

  // Result checker
  always @(posedge clk_i) begin
    amp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_amps.size() == 0) begin
        $error("result beat with none pending, out_index %h", out_index_o);
        fail_count++;
      end else begin
        want = expected_amps.pop_front();
        checked_count++;
        if (out_index_o !== want.index) begin
          $error("out_index: expected %h, got %h", want.index, out_index_o);
          fail_count++;
        end
        if (out_re_o !== want.re) begin
          $error("out_re: expected %0d, got %0d", want.re, out_re_o);
          fail_count++;
        end
        if (out_im_o !== want.im) begin
          $error("out_im: expected %0d, got %0d", want.im, out_im_o);
          fail_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: %0d results still pending", expected_amps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = dgam_pkg::REG_COEF0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    amp_index_i = '0;
    amp_re_i    = '0;
    amp_im_i    = '0;
    reset_gate_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_coef_extremes();
    test_entry_select();
    test_random_phases();

    in_valid_i <= 1'b0;
    while (expected_amps.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d amplitudes under %0d gate settings; %0d results compared.",
             sent_count, setting_count, checked_count);
    $display("Covered: coefficient extremes, rounding ties, every gate_qubits code, %s",
             "masked entries.");
    if (fail_count == 0 && expected_amps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
